@@ rtl/sndx_pkg.sv @@
// Soundex encoder package: item and result types, letter code table.
// No dependencies; used by sndx_front, sndx_back and soundex_encoder_core.
`default_nettype none

package sndx_pkg;

   localparam logic [2:0] CODE_SEPARATOR   = 3'd0;
   localparam logic [2:0] CODE_TRANSPARENT = 3'd7;
   localparam logic [6:0] ASCII_UPPER_A    = 7'd65;

   typedef struct packed {
      logic       last;
      logic       letter;
      logic [4:0] idx;
      logic [2:0] code;
   } item_type;

   typedef struct packed {
      logic [6:0] lead_letter;
      logic [2:0] digit_one;
      logic [2:0] digit_two;
      logic [2:0] digit_three;
      logic       no_letters;
   } result_type;

   function automatic logic [2:0] letter_code(input logic [4:0] idx);
      logic [2:0] code;
      case (idx)
         5'd1, 5'd5, 5'd15, 5'd21:                          code = 3'd1;
         5'd2, 5'd6, 5'd9, 5'd10, 5'd16, 5'd18, 5'd23, 5'd25: code = 3'd2;
         5'd3, 5'd19:                                       code = 3'd3;
         5'd11:                                             code = 3'd4;
         5'd12, 5'd13:                                      code = 3'd5;
         5'd17:                                             code = 3'd6;
         5'd7, 5'd22:                                       code = CODE_TRANSPARENT;
         default:                                           code = CODE_SEPARATOR;
      endcase
      return code;
   endfunction

endpackage

`default_nettype wire

@@ rtl/sndx_queue.sv @@
// Small first-in first-out queue of packed words.
// Generic; used between front and back and at the result side.
`default_nettype none

module sndx_queue #(
   parameter int WIDTH      = 16,
   parameter int DEPTH_LOG2 = 2
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             push,
   input  wire logic [WIDTH-1:0] wdata,
   output logic                  full,
   input  wire logic             pop,
   output logic      [WIDTH-1:0] rdata,
   output logic                  empty
);

   localparam int DEPTH = 1 << DEPTH_LOG2;

   logic [WIDTH-1:0]  mem_ff [DEPTH];
   logic [DEPTH_LOG2:0] wptr_ff, wptr_in;
   logic [DEPTH_LOG2:0] rptr_ff, rptr_in;
   logic do_push, do_pop;

   assign empty = (wptr_ff == rptr_ff);
   assign full  = (wptr_ff[DEPTH_LOG2] != rptr_ff[DEPTH_LOG2]) &&
                  (wptr_ff[DEPTH_LOG2-1:0] == rptr_ff[DEPTH_LOG2-1:0]);
   assign do_push = push && !full;
   assign do_pop  = pop && !empty;
   assign rdata   = mem_ff[rptr_ff[DEPTH_LOG2-1:0]];

   always_comb begin
      wptr_in = wptr_ff + (DEPTH_LOG2+1)'(do_push);
      rptr_in = rptr_ff + (DEPTH_LOG2+1)'(do_pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wptr_ff <= '0;
         rptr_ff <= '0;
      end else begin
         wptr_ff <= wptr_in;
         rptr_ff <= rptr_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wptr_ff[DEPTH_LOG2-1:0]] <= wdata;
      end
   end

endmodule

`default_nettype wire

@@ rtl/sndx_front.sv @@
// Front end: folds case, flags non-letters and looks up the Soundex code.
// Depends on sndx_pkg.
`default_nettype none

module sndx_front (
   input  wire logic [7:0]  char_in,
   input  wire logic        last_char,
   output sndx_pkg::item_type item
);

   always_comb begin
      item.last   = last_char;
      item.letter = (char_in inside {[8'h41:8'h5A], [8'h61:8'h7A]});
      item.idx    = char_in[4:0] - 5'd1;
      item.code   = sndx_pkg::letter_code(item.idx);
   end

endmodule

`default_nettype wire

@@ rtl/sndx_back.sv @@
// Back end: run collapsing, digit collection and result assembly.
// Depends on sndx_pkg.
`default_nettype none

module sndx_back #(
   parameter int CODE_DIGITS = 3
) (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 in_empty,
   input  wire sndx_pkg::item_type   in_item,
   output logic                      in_pop,
   input  wire logic                 out_full,
   output logic                      out_push,
   output sndx_pkg::result_type      out_result
);

   localparam int CW = $clog2(CODE_DIGITS + 1);

   logic          have_lead_ff, have_lead_in, have_lead_upd;
   logic [4:0]    lead_ff, lead_in, lead_upd;
   logic [2:0]    prev_ff, prev_in, prev_upd;
   logic [CW-1:0] count_ff, count_in, count_upd;
   logic [2:0]    store_ff [CODE_DIGITS];
   logic [2:0]    store_in [CODE_DIGITS];
   logic [2:0]    digit_out [3];
   logic          take, add;

   assign take     = !in_empty && !out_full;
   assign in_pop   = take;
   assign out_push = take && in_item.last;

   always_comb begin
      have_lead_upd = have_lead_ff;
      lead_upd      = lead_ff;
      prev_upd      = prev_ff;
      count_upd     = count_ff;
      add           = 1'b0;
      if (take && in_item.letter) begin
         if (!have_lead_ff) begin
            have_lead_upd = 1'b1;
            lead_upd      = in_item.idx;
            if (in_item.code != sndx_pkg::CODE_TRANSPARENT) begin
               prev_upd = in_item.code;
            end
         end else if (in_item.code != sndx_pkg::CODE_TRANSPARENT) begin
            add = (in_item.code != sndx_pkg::CODE_SEPARATOR) &&
                  (in_item.code != prev_ff) && (count_ff < CW'(CODE_DIGITS));
            if (add) begin
               count_upd = count_ff + CW'(1);
            end
            prev_upd = in_item.code;
         end
      end
      for (int k = 0; k < CODE_DIGITS; k++) begin
         store_in[k] = (add && count_ff == CW'(k)) ? in_item.code : store_ff[k];
      end
   end

   for (genvar g = 0; g < 3; g++) begin : g_digit
      if (g < CODE_DIGITS) begin : g_used
         assign digit_out[g] = (count_upd > CW'(g)) ? store_in[g] : 3'd0;
      end else begin : g_pad
         assign digit_out[g] = 3'd0;
      end
   end

   always_comb begin
      if (have_lead_upd) begin
         out_result.lead_letter = sndx_pkg::ASCII_UPPER_A + {2'b00, lead_upd};
         out_result.digit_one   = digit_out[0];
         out_result.digit_two   = digit_out[1];
         out_result.digit_three = digit_out[2];
         out_result.no_letters  = 1'b0;
      end else begin
         out_result = '0;
         out_result.no_letters = 1'b1;
      end
   end

   always_comb begin
      if (out_push) begin
         have_lead_in = 1'b0;
         lead_in      = '0;
         prev_in      = sndx_pkg::CODE_SEPARATOR;
         count_in     = '0;
      end else begin
         have_lead_in = have_lead_upd;
         lead_in      = lead_upd;
         prev_in      = prev_upd;
         count_in     = count_upd;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         have_lead_ff <= 1'b0;
         lead_ff      <= '0;
         prev_ff      <= sndx_pkg::CODE_SEPARATOR;
         count_ff     <= '0;
      end else begin
         have_lead_ff <= have_lead_in;
         lead_ff      <= lead_in;
         prev_ff      <= prev_in;
         count_ff     <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      for (int k = 0; k < CODE_DIGITS; k++) begin
         store_ff[k] <= store_in[k];
      end
   end

endmodule

`default_nettype wire

@@ rtl/soundex_encoder_core.sv @@
// Soundex encoder top level: front end, item queue, back end, result queue.
// Depends on sndx_pkg, sndx_front, sndx_queue and sndx_back.
// One byte per cycle while full is low; a result is registered in the result queue.
// The back end updates its run state once per cycle from a queued item if results have room.
// Reset is synchronous, active high, and empties both queues and clears the state.
`default_nettype none

module soundex_encoder_core #(
   parameter int CODE_DIGITS = 3
) (
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       push,
   output logic            full,
   input  wire logic [7:0] req_char_in,
   input  wire logic       req_last_char,
   output logic            empty,
   input  wire logic       pop,
   output logic [6:0]      rsp_lead_letter,
   output logic [2:0]      rsp_digit_one,
   output logic [2:0]      rsp_digit_two,
   output logic [2:0]      rsp_digit_three,
   output logic            rsp_no_letters
);

   localparam int ItemWidth   = $bits(sndx_pkg::item_type);
   localparam int ResultWidth = $bits(sndx_pkg::result_type);

   sndx_pkg::item_type   front_item, back_item;
   sndx_pkg::result_type back_result, rsp_result;
   logic item_empty, item_pop, res_full, res_push;

   sndx_front u_front (
      .char_in   (req_char_in),
      .last_char (req_last_char),
      .item      (front_item)
   );

   sndx_queue #(.WIDTH(ItemWidth), .DEPTH_LOG2(2)) u_item_queue (
      .clock (clock),
      .reset (reset),
      .push  (push),
      .wdata (front_item),
      .full  (full),
      .pop   (item_pop),
      .rdata (back_item),
      .empty (item_empty)
   );

   sndx_back #(.CODE_DIGITS(CODE_DIGITS)) u_back (
      .clock      (clock),
      .reset      (reset),
      .in_empty   (item_empty),
      .in_item    (back_item),
      .in_pop     (item_pop),
      .out_full   (res_full),
      .out_push   (res_push),
      .out_result (back_result)
   );

   sndx_queue #(.WIDTH(ResultWidth), .DEPTH_LOG2(1)) u_result_queue (
      .clock (clock),
      .reset (reset),
      .push  (res_push),
      .wdata (back_result),
      .full  (res_full),
      .pop   (pop),
      .rdata (rsp_result),
      .empty (empty)
   );

   assign rsp_lead_letter = rsp_result.lead_letter;
   assign rsp_digit_one   = rsp_result.digit_one;
   assign rsp_digit_two   = rsp_result.digit_two;
   assign rsp_digit_three = rsp_result.digit_three;
   assign rsp_no_letters  = rsp_result.no_letters;

`ifndef SYNTHESIS
   a_reset_empties : assert property (@(posedge clock)
      reset |=> (empty && !full))
      else $error("queues not empty after reset");

   a_no_letters_zero : assert property (@(posedge clock) disable iff (reset)
      (!empty && rsp_no_letters) |-> (rsp_lead_letter == 7'd0 &&
         rsp_digit_one == 3'd0 && rsp_digit_two == 3'd0 && rsp_digit_three == 3'd0))
      else $error("letterless result carries nonzero fields");

   a_lead_is_letter : assert property (@(posedge clock) disable iff (reset)
      (!empty && !rsp_no_letters) |-> (rsp_lead_letter >= 7'd65 &&
         rsp_lead_letter <= 7'd90))
      else $error("lead letter outside A to Z");

   a_digit_range : assert property (@(posedge clock) disable iff (reset)
      !empty |-> (rsp_digit_one != 3'd7 && rsp_digit_two != 3'd7 &&
         rsp_digit_three != 3'd7))
      else $error("digit holds the transparent code");
`endif

endmodule

`default_nettype wire

@@ verif/testbench.sv @@
// Testbench for soundex_encoder_core: streams name bytes through the push/full side
// and checks every code popped from the result side against a local Soundex predictor.
// Depends on sndx_pkg and soundex_encoder_core.
`timescale 1ns / 100ps

module testbench;

   localparam int CODE_DIGITS    = 3;
   localparam int WATCHDOG_LIMIT = 3000;
   localparam int SQUEEZE_CYCLES = 400;

   typedef struct {
      bit [7:0] ch;
      bit       last;
   } name_byte_type;

   logic       clock = 1'b0;
   logic       reset = 1'b1;
   logic       push = 1'b0;
   logic       full;
   logic [7:0] req_char_in = 8'h00;
   logic       req_last_char = 1'b0;
   logic       empty;
   logic       pop = 1'b0;
   logic [6:0] rsp_lead_letter;
   logic [2:0] rsp_digit_one;
   logic [2:0] rsp_digit_two;
   logic [2:0] rsp_digit_three;
   logic       rsp_no_letters;

   name_byte_type        pending_bytes[$];
   sndx_pkg::result_type expected_codes[$];

   bit       have_lead = 1'b0;
   bit [6:0] lead_char = '0;
   bit [2:0] prev_code = sndx_pkg::CODE_SEPARATOR;
   int       digit_count = 0;
   bit [2:0] digits[CODE_DIGITS];

   int  mismatches = 0;
   int  accepted_bytes = 0;
   int  idle_cycles = 0;
   bit  byte_taken = 1'b0;
   int  send_gap = 0;
   bit  calm_send = 1'b0;
   int  stall_left = 0;
   int  hold_left = 0;
   int  next_squeeze = 100;
   bit  calm_recv = 1'b0;

   soundex_encoder_core #(.CODE_DIGITS(CODE_DIGITS)) dut (
      .clock           (clock),
      .reset           (reset),
      .push            (push),
      .full            (full),
      .req_char_in     (req_char_in),
      .req_last_char   (req_last_char),
      .empty           (empty),
      .pop             (pop),
      .rsp_lead_letter (rsp_lead_letter),
      .rsp_digit_one   (rsp_digit_one),
      .rsp_digit_two   (rsp_digit_two),
      .rsp_digit_three (rsp_digit_three),
      .rsp_no_letters  (rsp_no_letters)
   );

   always #1 clock = ~clock;

   function automatic bit [7:0] fold_upper(input bit [7:0] c);
      if (c >= "a" && c <= "z") begin
         return c - 8'd32;
      end
      return c;
   endfunction

   function automatic bit is_letter(input bit [7:0] c);
      bit [7:0] up;
      up = fold_upper(c);
      return (up >= "A" && up <= "Z");
   endfunction

   function automatic bit [2:0] soundex_digit(input bit [7:0] up);
      case (up)
         "B", "F", "P", "V":                     return 3'd1;
         "C", "G", "J", "K", "Q", "S", "X", "Z": return 3'd2;
         "D", "T":                               return 3'd3;
         "L":                                    return 3'd4;
         "M", "N":                               return 3'd5;
         "R":                                    return 3'd6;
         "H", "W":                               return sndx_pkg::CODE_TRANSPARENT;
         default:                                return sndx_pkg::CODE_SEPARATOR;
      endcase
   endfunction

   task automatic encode_byte(input bit [7:0] raw, input bit last);
      bit [7:0]             up;
      bit [2:0]             code;
      sndx_pkg::result_type res;
      up = fold_upper(raw);
      if (up >= "A" && up <= "Z") begin
         code = soundex_digit(up);
         if (!have_lead) begin
            have_lead = 1'b1;
            lead_char = up[6:0];
            if (code != sndx_pkg::CODE_TRANSPARENT) prev_code = code;
         end else if (code != sndx_pkg::CODE_TRANSPARENT) begin
            if (code != sndx_pkg::CODE_SEPARATOR && code != prev_code &&
                digit_count < CODE_DIGITS) begin
               digits[digit_count] = code;
               digit_count++;
            end
            prev_code = code;
         end
      end
      if (last) begin
         res = '0;
         if (have_lead) begin
            res.lead_letter = lead_char;
            res.digit_one   = (digit_count > 0) ? digits[0] : 3'd0;
            res.digit_two   = (digit_count > 1) ? digits[1] : 3'd0;
            res.digit_three = (digit_count > 2) ? digits[2] : 3'd0;
         end else begin
            res.no_letters = 1'b1;
         end
         expected_codes.push_back(res);
         have_lead   = 1'b0;
         lead_char   = '0;
         prev_code   = sndx_pkg::CODE_SEPARATOR;
         digit_count = 0;
         foreach (digits[k]) digits[k] = 3'd0;
      end
   endtask

   task automatic log_mismatch(input string why, input sndx_pkg::result_type want,
                               input sndx_pkg::result_type got);
      mismatches++;
      if (mismatches <= 10) begin
         $display("%s: expected %c %0d%0d%0d nl=%0d, got 0x%h %0d%0d%0d nl=%0d", why,
                  want.lead_letter, want.digit_one, want.digit_two, want.digit_three,
                  want.no_letters, got.lead_letter, got.digit_one, got.digit_two,
                  got.digit_three, got.no_letters);
      end
   endtask

   task automatic add_byte(input bit [7:0] ch, input bit last);
      name_byte_type nb;
      nb.ch   = ch;
      nb.last = last;
      pending_bytes.push_back(nb);
   endtask

   task automatic add_text(input string s);
      for (int i = 0; i < s.len(); i++) add_byte(s[i], i == s.len() - 1);
   endtask

   function automatic bit [7:0] random_char(input int mode);
      string    runny;
      bit [7:0] c;
      runny = "BFPVHWAEIOUYCSKLDT";
      if (mode == 2 || $urandom_range(0, 99) < 8) begin
         c = 8'($urandom_range(0, 255));
         if (is_letter(c)) c = c ^ 8'h80;
      end else if (mode == 1) begin
         c = runny[$urandom_range(0, runny.len() - 1)];
      end else begin
         c = 8'd65 + 8'($urandom_range(0, 25));
      end
      if (is_letter(c) && $urandom_range(0, 1)) c = c | 8'h20;
      return c;
   endfunction

   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (r < 60) return 0;
      if (r < 90) return $urandom_range(1, 3);
      if (r < 97) return $urandom_range(4, 10);
      return $urandom_range(20, 40);
   endfunction

   // sender: advance on acceptance, hold otherwise
   always @(negedge clock) begin
      if (!reset) begin
         if (!push || byte_taken) begin
            if (send_gap > 0) begin
               push <= 1'b0;
               send_gap--;
            end else if (pending_bytes.size() > 0) begin
               push          <= 1'b1;
               req_char_in   <= pending_bytes[0].ch;
               req_last_char <= pending_bytes[0].last;
               void'(pending_bytes.pop_front());
               if ($urandom_range(0, 49) == 0) calm_send = !calm_send;
               send_gap = calm_send ? 0 : pick_gap();
            end else begin
               push <= 1'b0;
            end
         end
      end
      byte_taken = 1'b0;
   end

   // receiver: random stalls plus long hold-offs to back up the block
   always @(negedge clock) begin
      if (!reset) begin
         if (hold_left == 0 && accepted_bytes >= next_squeeze) begin
            hold_left = SQUEEZE_CYCLES;
            next_squeeze += 250;
         end
         if (hold_left > 0) begin
            pop <= 1'b0;
            hold_left--;
         end else if (stall_left > 0) begin
            pop <= 1'b0;
            stall_left--;
         end else begin
            pop <= 1'b1;
            if ($urandom_range(0, 49) == 0) calm_recv = !calm_recv;
            stall_left = calm_recv ? 0 : pick_gap();
         end
      end
   end

   always @(posedge clock) begin
      sndx_pkg::result_type got;
      if (!reset) begin
         if (push && !full) begin
            encode_byte(req_char_in, req_last_char);
            accepted_bytes++;
            byte_taken = 1'b1;
         end
         if (pop && !empty) begin
            got = '{lead_letter: rsp_lead_letter, digit_one: rsp_digit_one,
                    digit_two: rsp_digit_two, digit_three: rsp_digit_three,
                    no_letters: rsp_no_letters};
            if (expected_codes.size() == 0) begin
               log_mismatch("unexpected code", '0, got);
            end else begin
               if (expected_codes[0].lead_letter !== got.lead_letter ||
                   expected_codes[0].digit_one !== got.digit_one ||
                   expected_codes[0].digit_two !== got.digit_two ||
                   expected_codes[0].digit_three !== got.digit_three ||
                   expected_codes[0].no_letters !== got.no_letters) begin
                  log_mismatch("code mismatch", expected_codes[0], got);
               end
               void'(expected_codes.pop_front());
            end
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (push && !full) || (pop && !empty)) begin
         idle_cycles <= 0;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
      if (idle_cycles >= WATCHDOG_LIMIT) begin
         $display("Test completed with failures");
         $finish;
      end
   end

   initial begin
      int counted;
      int len;
      int mode;
      int r;
      bit [7:0] c;

      add_byte(8'h00, 1'b0);
      add_byte(8'h40, 1'b0);
      add_byte(8'h5B, 1'b0);
      add_byte(8'h60, 1'b0);
      add_byte(8'h7B, 1'b0);
      add_byte(8'hFF, 1'b1);
      add_text("z");
      add_text("ACHC");
      add_text("BaB");
      add_text("Pft");
      add_text("Lm-ndrZ");
      add_text("WL");

      counted = pending_bytes.size();
      while (counted < 450) begin
         r = $urandom_range(0, 99);
         if (r < 10) len = $urandom_range(1, 2);
         else if (r < 85) len = $urandom_range(3, 8);
         else len = $urandom_range(9, 14);
         r = $urandom_range(0, 99);
         mode = (r < 5) ? 2 : ((r < 40) ? 1 : 0);
         for (int i = 0; i < len; i++) begin
            c = random_char(mode);
            add_byte(c, i == len - 1);
            counted++;
         end
      end

      repeat (7) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      while (pending_bytes.size() != 0 || push || expected_codes.size() != 0) begin
         @(posedge clock);
      end
      repeat (16) @(posedge clock);
      if (mismatches == 0) begin
         $display("Test completed successfully");
      end else begin
         $display("Test completed with failures");
      end
      $finish;
   end

endmodule
